>>> rtl/core/hsv_to_bgr_pixel_assert.svh
// Assertion macros for the pixel converter checker.
`ifndef HSV_TO_BGR_PIXEL_ASSERT_SVH
`define HSV_TO_BGR_PIXEL_ASSERT_SVH

// Same-cycle implication, off during reset.
`define HBP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbp assertion failed");

// Next-cycle implication, off during reset.
`define HBP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbp assertion failed");

// Same-cycle implication, active through reset.
`define HBP_ASSERT_ALW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("hbp assertion failed");

`endif

>>> rtl/core/hbp_pkg.sv
`default_nettype none
package hbp_pkg;

  localparam int unsigned HueW    = 13;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WeightW = 10;
  localparam int unsigned ProdW   = 16;
  localparam int unsigned XprodW  = 18;

  localparam logic [HueW-1:0]    HUE_SECTOR = 13'd960;
  localparam logic [HueW-1:0]    HUE_FULL   = 13'd5760;
  localparam logic [WeightW-1:0] WEIGHT_MAX = 10'd960;
  localparam int unsigned        XprodShift = 6;
  localparam logic [14:0]        RECIP15    = 15'd17477;
  localparam int unsigned        RecipShift = 18;

  typedef enum logic [2:0] {
    SEC_RED_GRN = 3'd0,
    SEC_GRN_RED = 3'd1,
    SEC_GRN_BLU = 3'd2,
    SEC_BLU_GRN = 3'd3,
    SEC_BLU_RED = 3'd4,
    SEC_RED_BLU = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t             sector;
    logic [WeightW-1:0]  weight;
    logic [ProdW-1:0]    prod;
    logic [ByteW-1:0]    val;
  } s1_t;

  typedef struct packed {
    sector_t             sector;
    logic [WeightW-1:0]  weight;
    logic [ByteW-1:0]    chroma;
    logic [ByteW-1:0]    val;
  } s2_t;

  typedef struct packed {
    sector_t             sector;
    logic [XprodW-1:0]   xprod;
    logic [ByteW-1:0]    chroma;
    logic [ByteW-1:0]    offset;
  } s3_t;

  typedef struct packed {
    sector_t             sector;
    logic [ByteW-1:0]    xval;
    logic [ByteW-1:0]    chroma;
    logic [ByteW-1:0]    offset;
  } s4_t;

  // floor(p / 255) for p up to 65279
  function automatic logic [ByteW-1:0] div255(input logic [ProdW-1:0] p);
    logic [ProdW:0] y;
    logic [ProdW:0] s;
    y = {1'b0, p} + 17'd1;
    s = y + (y >> 8);
    return s[15:8];
  endfunction

  // 0..255 clamp of a 9-bit sum
  function automatic logic [ByteW-1:0] sat8(input logic [ByteW:0] s);
    return s[ByteW] ? {ByteW{1'b1}} : s[ByteW-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/hbp_if.sv
`default_nettype none
interface hbp_hsv_if
  import hbp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [HueW-1:0]   hue;
  logic [ByteW-1:0]  sat;
  logic [ByteW-1:0]  val;

  modport source (output valid, hue, sat, val, input ready);
  modport sink   (input valid, hue, sat, val, output ready);
endinterface

interface hbp_bgr_if
  import hbp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  blue;
  logic [ByteW-1:0]  green;
  logic [ByteW-1:0]  red;

  modport source (output valid, blue, green, red, input ready);
  modport sink   (input valid, blue, green, red, output ready);
endinterface
`default_nettype wire

>>> rtl/core/hbp_chroma.sv
`default_nettype none
module hbp_chroma
  import hbp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [HueW-1:0]  hue,
  input  wire logic [ByteW-1:0] sat,
  input  wire logic [ByteW-1:0] val,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output s2_t                   out_data
);

  logic            v1;
  s1_t             d1;
  s1_t             d1_next;
  logic            en1;
  logic            en2;
  logic [HueW-1:0] hue_c;
  logic [2:0]      sec;
  logic [HueW-1:0] frac;

  assign en2      = !out_valid || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_comb begin
    hue_c = (hue > HUE_FULL) ? HUE_FULL : hue;
    if (hue_c == HUE_FULL) begin
      sec  = 3'd5;
      frac = HUE_SECTOR;
    end else begin
      sec = 3'((hue_c >= 13'd960)  ? 1 : 0) + 3'((hue_c >= 13'd1920) ? 1 : 0)
          + 3'((hue_c >= 13'd2880) ? 1 : 0) + 3'((hue_c >= 13'd3840) ? 1 : 0)
          + 3'((hue_c >= 13'd4800) ? 1 : 0);
      frac = hue_c - 13'(sec * HUE_SECTOR);
    end
    d1_next.sector = sector_t'(sec);
    d1_next.weight = sec[0] ? (WEIGHT_MAX - frac[WeightW-1:0]) : frac[WeightW-1:0];
    d1_next.prod   = val * sat;
    d1_next.val    = val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1) begin
      d1 <= d1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= v1;
    end
    if (en2) begin
      out_data.sector <= d1.sector;
      out_data.weight <= d1.weight;
      out_data.chroma <= div255(d1.prod);
      out_data.val    <= d1.val;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/hbp_hue_mix.sv
`default_nettype none
module hbp_hue_mix
  import hbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  s2_t       in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output s4_t       out_data
);

  logic                    v3;
  s3_t                     d3;
  logic                    en3;
  logic                    en4;
  logic [XprodW-XprodShift-1:0] n;
  logic [26:0]             q;

  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign in_ready = en3;

  // x = xprod / 960 = (xprod >> 6) / 15
  assign n = d3.xprod[XprodW-1:XprodShift];
  assign q = n * RECIP15;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= in_valid;
    end
    if (en3) begin
      d3.sector <= in_data.sector;
      d3.xprod  <= in_data.chroma * in_data.weight;
      d3.chroma <= in_data.chroma;
      d3.offset <= in_data.val - in_data.chroma;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= v3;
    end
    if (en4) begin
      out_data.sector <= d3.sector;
      out_data.xval   <= q[RecipShift+ByteW-1:RecipShift];
      out_data.chroma <= d3.chroma;
      out_data.offset <= d3.offset;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/hbp_assemble.sv
`default_nettype none
module hbp_assemble
  import hbp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  s4_t        in_data,
  hbp_bgr_if.source  bgr
);

  logic             en5;
  logic [ByteW-1:0] r;
  logic [ByteW-1:0] g;
  logic [ByteW-1:0] b;

  assign en5      = !bgr.valid || bgr.ready;
  assign in_ready = en5;

  always_comb begin
    case (in_data.sector)
      SEC_RED_GRN: begin r = in_data.chroma; g = in_data.xval;   b = '0;             end
      SEC_GRN_RED: begin r = in_data.xval;   g = in_data.chroma; b = '0;             end
      SEC_GRN_BLU: begin r = '0;             g = in_data.chroma; b = in_data.xval;   end
      SEC_BLU_GRN: begin r = '0;             g = in_data.xval;   b = in_data.chroma; end
      SEC_BLU_RED: begin r = in_data.xval;   g = '0;             b = in_data.chroma; end
      default:     begin r = in_data.chroma; g = '0;             b = in_data.xval;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bgr.valid <= 1'b0;
    end else if (en5) begin
      bgr.valid <= in_valid;
    end
    if (en5) begin
      bgr.blue  <= sat8({1'b0, b} + {1'b0, in_data.offset});
      bgr.green <= sat8({1'b0, g} + {1'b0, in_data.offset});
      bgr.red   <= sat8({1'b0, r} + {1'b0, in_data.offset});
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/hsv_to_bgr_pixel.sv
// HSV to BGR pixel converter. Takes one HSV word per clock (hue in 1/16 degree,
// 0..5760, larger values treated as 5760; saturation and value 0..255) and
// returns blue, green and red bytes, one word per clock when the output is
// not stalled. The five register stages are: sector split and value*saturation
// multiply, divide by 255, chroma*weight multiply, divide by 960 through a
// reciprocal multiply, channel select and offset add. Each stage holds its
// own valid bit, so bubbles close up under backpressure and the input stays
// ready until every stage holds a word.
`default_nettype none
module hsv_to_bgr_pixel
  import hbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  hbp_hsv_if.sink   hsv,
  hbp_bgr_if.source bgr
);

  logic c_valid;
  logic c_ready;
  s2_t  c_data;
  logic m_valid;
  logic m_ready;
  s4_t  m_data;

  hbp_chroma u_chroma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hsv.valid),
    .in_ready  (hsv.ready),
    .hue       (hsv.hue),
    .sat       (hsv.sat),
    .val       (hsv.val),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_data  (c_data)
  );

  hbp_hue_mix u_hue_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .in_data   (c_data),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .out_data  (m_data)
  );

  hbp_assemble u_assemble (
    .clk      (clk),
    .rst      (rst),
    .in_valid (m_valid),
    .in_ready (m_ready),
    .in_data  (m_data),
    .bgr      (bgr)
  );

endmodule
`default_nettype wire

>>> rtl/core/hbp_check.sv
`default_nettype none
`include "hsv_to_bgr_pixel_assert.svh"
module hbp_check
  import hbp_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [ByteW-1:0] blue,
  input wire logic [ByteW-1:0] green,
  input wire logic [ByteW-1:0] red
);

  `HBP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `HBP_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(blue) && $stable(green) && $stable(red))
  `HBP_ASSERT_IMP(a_ready_when_drained, !out_valid, in_ready)
  `HBP_ASSERT_ALW(a_reset_empty, $past(rst), !out_valid)

endmodule

bind hsv_to_bgr_pixel hbp_check u_hbp_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (hsv.ready),
  .out_valid (bgr.valid),
  .out_ready (bgr.ready),
  .blue      (bgr.blue),
  .green     (bgr.green),
  .red       (bgr.red)
);
`default_nettype wire
